// ===== sv/bst_pkg.sv =====
package bst_pkg;

  localparam int unsigned MaxSlots = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CtrlW    = 9;
  localparam int unsigned CountW   = 5;

  localparam logic [CtrlW-1:0] CtrlEnable  = 9'h001;
  localparam logic [CtrlW-1:0] CtrlPrivAny = 9'h006;
  localparam logic [CtrlW-1:0] CtrlByteAny = 9'h1E0;
  localparam logic [CtrlW-1:0] CtrlArmed   = CtrlEnable | CtrlPrivAny | CtrlByteAny;

  typedef enum logic [2:0] {
    OP_SET        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_REMOVE_ALL = 3'd2,
    OP_ACTIVATE   = 3'd3,
    OP_DEACTIVATE = 3'd4
  } op_e;

  typedef enum logic {
    CFG_ENABLED = 1'b0,
    CFG_SLOTS   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [AddrW-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic             is_write;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] value_word;
    logic [CtrlW-1:0] control_word;
    logic             success;
    logic             last;
  } res_t;

endpackage

// ===== sv/breakpoint_slot_table_core.sv =====
// Breakpoint slot table. A command is taken when start_i is high and busy_o is low.
// It walks the slots one per cycle through a 16 x 32 slot memory with a registered
// read. After accepting a command it walks up to slots_in_use slots, ending early
// when set or remove finds its slot, then gives the status result. Comparator writes
// come out in slot order, each on result_o for one cycle with result_valid_o high,
// followed by the status result with last set. The receiver cannot stall the
// results; every transfer is taken when shown. The user must write configuration
// only while busy_o is low and no result is pending; the block does not enforce it.
module breakpoint_slot_table_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bst_pkg::cmd_t       cmd_i,
  output logic                busy_o,
  output logic                result_valid_o,
  output bst_pkg::res_t       result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [4:0]          cfg_data_i
);
  import bst_pkg::*;

  state_e              state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [CountW-1:0]   lim_q, lim_d;
  logic [SlotW-1:0]    idx_q, idx_d;
  logic                ok_q, ok_d;
  logic                act_q, act_d;
  logic                enabled_q;
  logic [CountW-1:0]   slots_q;
  logic [MaxSlots-1:0] valid_q, valid_d;
  logic [AddrW-1:0]    mem_q [MaxSlots];
  logic [AddrW-1:0]    rdata_q;
  logic                rvld_q;
  logic [SlotW-1:0]    raddr;
  logic                mem_we;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;
  logic [AddrW-1:0]    cur;
  logic                walk_end;
  logic                hit;

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= addr_q;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= 3'd0;
      lim_q       <= '0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      act_q       <= 1'b0;
      enabled_q   <= 1'b0;
      slots_q     <= CountW'(MaxSlots);
      valid_q     <= '0;
      rvld_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      lim_q       <= lim_d;
      idx_q       <= idx_d;
      ok_q        <= ok_d;
      valid_q     <= valid_d;
      rvld_q      <= valid_q[raddr];
      res_valid_q <= res_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_ENABLED) begin
        enabled_q <= cfg_data_i[0];
        act_q     <= 1'b0;
      end else begin
        act_q <= act_d;
      end
      if (cfg_we_i && cfg_idx_i == CFG_SLOTS) begin
        slots_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    ok_d        = ok_q;
    act_d       = act_q;
    valid_d     = valid_q;
    mem_we      = 1'b0;
    raddr       = '0;
    res_valid_d = 1'b0;
    res_d       = '0;
    hit         = 1'b0;
    cur         = rvld_q ? rdata_q : '0;
    walk_end    = (({1'b0, idx_q} + CountW'(1)) == lim_q);

    case (state_q)
      ST_IDLE: begin
        raddr = '0;
        if (start_i) begin
          op_d   = cmd_i.op;
          addr_d = cmd_i.address;
          idx_d  = '0;
          lim_d  = (slots_q > CountW'(MaxSlots)) ? CountW'(MaxSlots) : slots_q;
          ok_d   = enabled_q && (cmd_i.op == OP_REMOVE_ALL || cmd_i.op == OP_ACTIVATE ||
                                 cmd_i.op == OP_DEACTIVATE);
          if (enabled_q && cmd_i.op == OP_ACTIVATE) begin
            act_d = 1'b1;
          end
          if (enabled_q && cmd_i.op == OP_DEACTIVATE) begin
            act_d = 1'b0;
          end
          if (enabled_q && cmd_i.op <= OP_DEACTIVATE && lim_d != '0) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_STATUS;
          end
        end
      end
      ST_WALK: begin
        raddr = idx_q + SlotW'(1);
        res_d.slot = idx_q;
        case (op_q)
          OP_SET: begin
            if (cur == '0) begin
              mem_we         = 1'b1;
              valid_d[idx_q] = 1'b1;
              ok_d           = 1'b1;
              hit            = 1'b1;
              if (act_q) begin
                res_valid_d        = 1'b1;
                res_d.is_write     = 1'b1;
                res_d.value_word   = addr_q;
                res_d.control_word = CtrlArmed;
              end
            end
          end
          OP_REMOVE: begin
            if (cur == addr_q) begin
              valid_d[idx_q] = 1'b0;
              ok_d           = 1'b1;
              hit            = 1'b1;
              if (act_q) begin
                res_valid_d    = 1'b1;
                res_d.is_write = 1'b1;
              end
            end
          end
          OP_REMOVE_ALL: begin
            if (cur != '0) begin
              valid_d[idx_q] = 1'b0;
              if (act_q) begin
                res_valid_d    = 1'b1;
                res_d.is_write = 1'b1;
              end
            end
          end
          OP_ACTIVATE: begin
            if (cur != '0) begin
              res_valid_d        = 1'b1;
              res_d.is_write     = 1'b1;
              res_d.value_word   = cur;
              res_d.control_word = CtrlArmed;
            end
          end
          OP_DEACTIVATE: begin
            if (cur != '0) begin
              res_valid_d    = 1'b1;
              res_d.is_write = 1'b1;
            end
          end
          default: begin
            hit = 1'b1;
          end
        endcase
        if (hit || walk_end) begin
          state_d = ST_STATUS;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      ST_STATUS: begin
        res_valid_d   = 1'b1;
        res_d.success = ok_q;
        res_d.last    = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
